// ===== rtl/sensor_timestamp_reconstructor_core_macros.svh =====
// Assertion macros for the timestamp reconstructor
`ifndef SENSOR_TIMESTAMP_RECONSTRUCTOR_CORE_MACROS_SVH
`define SENSOR_TIMESTAMP_RECONSTRUCTOR_CORE_MACROS_SVH
// implication checked every cycle outside reset
`define STR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define STR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/str_pkg.sv =====
// Shared types and constants for the timestamp reconstructor
`timescale 1ns / 1ps
package str_pkg;
  localparam logic [15:0] FMT_SPLIT = 16'hEEEE;
  localparam logic [15:0] FMT_READ  = 16'hFFFF;
  localparam logic [63:0] GYRO_RESET = 64'd5000000;

  localparam logic [1:0] SRC_RAW   = 2'd0;
  localparam logic [1:0] SRC_SPLIT = 2'd1;
  localparam logic [1:0] SRC_RING  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_IDX  = 2'd1;
  localparam logic [1:0] ST_BAD_FMT  = 2'd2;
  localparam logic [1:0] ST_ZERO_CNT = 2'd3;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_RAW,
    CMD_SPLIT,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [1:0]  status;
    logic [63:0] word;
    logic [63:0] now;
    logic [31:0] idx;
    logic [15:0] cnt;
    logic [7:0]  fstart;
    logic [63:0] sval;
  } req_t;

  typedef struct packed {
    logic [63:0] event_time;
    logic [1:0]  source;
    logic [1:0]  status;
    logic        clamped;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_RD_WAIT,
    S_CHECK,
    S_DIV,
    S_MUL,
    S_ADD,
    S_FILL_RD,
    S_FILL_WAIT,
    S_FILL_WR,
    S_FINAL_RD,
    S_FINAL_WAIT,
    S_OUT
  } bstate_t;
endpackage

// ===== rtl/str_front.sv =====
// Front end: classifies requests into commands for the back end
`timescale 1ns / 1ps
module str_front
  import str_pkg::*;
#(
  parameter int RING_SIZE = 32
) (
  input  logic        operation,
  input  logic        msg_kind,
  input  logic [63:0] frame_word,
  input  logic [63:0] now_time,
  input  logic [4:0]  fill_start,
  input  logic [4:0]  store_index,
  input  logic [63:0] store_value,
  output req_t        req
);
  logic [31:0] idx;
  logic [15:0] fmt;
  logic        fmt_ok;
  logic [7:0]  fs_tab [32];

  // fill start folded into the ring, one entry per fill_start value
  for (genvar g = 0; g < 32; g++) begin : g_fs
    assign fs_tab[g] = 8'(g % RING_SIZE);
  end

  assign idx = frame_word[31:0];
  assign fmt = frame_word[47:32];
  assign fmt_ok = (fmt == FMT_SPLIT) || (fmt == FMT_READ);

  always_comb begin
    req.word   = frame_word;
    req.now    = now_time;
    req.idx    = idx;
    req.cnt    = frame_word[63:48];
    req.fstart = fs_tab[fill_start];
    req.sval   = store_value;
    req.status = ST_OK;
    req.cmd    = CMD_RAW;
    if (!operation) begin
      req.cmd = CMD_STORE;
      req.idx = 32'(store_index);
    end else if (msg_kind) begin
      if (!fmt_ok) begin
        req.status = ST_BAD_FMT;
      end else if (idx >= 32'(RING_SIZE)) begin
        req.status = ST_BAD_IDX;
      end else if (fmt == FMT_SPLIT) begin
        req.cmd = CMD_SPLIT;
      end else begin
        req.cmd = CMD_READ;
      end
    end
  end
endmodule

// ===== rtl/str_fifo.sv =====
// Small request queue between front and back end
`timescale 1ns / 1ps
module str_fifo
  import str_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  req_t wdata,
  output logic full,
  input  logic rd,
  output req_t rdata,
  output logic empty
);
  req_t        mem [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && !empty) rptr <= ~rptr;
      count <= count + 2'(wr && !full) - 2'(rd && !empty);
    end
  end

  `include "sensor_timestamp_reconstructor_core_macros.svh"
  `STR_ASSERT_IMPL(a_no_over, clk, rst, full, !(count > 2'd2), "fifo count overflow")
  `STR_ASSERT_NEXT(a_push_cnt, clk, rst, wr && !full && !rd, count != 2'd0, "push lost")
  `STR_ASSERT_IMPL(a_ptrs, clk, rst, count == 2'd0 || count == 2'd2, wptr == rptr, "ptr mismatch")
endmodule

// ===== rtl/str_back.sv =====
// Back end: ring memory, serial divider, fill walk and result register
`timescale 1ns / 1ps
module str_back
  import str_pkg::*;
#(
  parameter int RING_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] gyro_period,
  input  logic        req_valid,
  input  req_t        req,
  output logic        req_take,
  output logic        res_valid,
  output res_t        res,
  input  logic        res_take
);
  localparam int AW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;

  logic [63:0] ring [RING_SIZE];
  logic [7:0]  cnt_mem [RING_SIZE];
  logic [RING_SIZE-1:0] ring_ok;
  logic [RING_SIZE-1:0] cnt_ok;

  bstate_t state, state_next;
  req_t    cur;
  logic [AW-1:0] idx, prv, walk, walk_nx;
  logic [63:0] rd_data, cur_v, prv_v, walk_v;
  logic [7:0]  ctr_v;
  logic [63:0] quo, rem, dvd;
  logic [6:0]  bitn;
  logic [63:0] prod;
  logic [64:0] trial;
  logic [AW-1:0] rd_addr;

  assign idx = cur.idx[AW-1:0];
  assign prv = (idx == '0) ? AW'(RING_SIZE - 1) : idx - 1'b1;
  assign walk_nx = (walk == AW'(RING_SIZE - 1)) ? '0 : walk + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (req_valid && !res_valid) state_next = S_RD;
      S_RD:        state_next = S_RD_WAIT;
      S_RD_WAIT:   state_next = S_CHECK;
      S_CHECK: begin
        if (cur.cmd == CMD_SPLIT && cur.cnt != 16'd0) state_next = S_DIV;
        else if (cur.cmd == CMD_READ && cur_v < rd_data
                 && walk != idx) state_next = S_FILL_RD;
        else if (cur.cmd == CMD_READ) state_next = S_FINAL_RD;
        else state_next = S_OUT;
      end
      S_DIV:       if (bitn == 7'd0) state_next = S_MUL;
      S_MUL:       state_next = S_ADD;
      S_ADD:       state_next = S_OUT;
      S_FILL_RD:   state_next = S_FILL_WAIT;
      S_FILL_WAIT: state_next = S_FILL_WR;
      S_FILL_WR:   state_next = (walk_nx == idx) ? S_FINAL_RD : S_FILL_RD;
      S_FINAL_RD:  state_next = S_FINAL_WAIT;
      S_FINAL_WAIT: state_next = S_OUT;
      S_OUT:       state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_take = (state == S_IDLE) && req_valid && !res_valid;
    rd_addr  = idx;
    case (state)
      S_RD:       rd_addr = idx;
      S_RD_WAIT:  rd_addr = prv;
      S_FILL_RD:  rd_addr = walk;
      S_FINAL_RD: rd_addr = idx;
      default:    rd_addr = idx;
    endcase
  end

  // ring memory, one read and one write port
  always_ff @(posedge clk) begin
    rd_data <= ring_ok[rd_addr] ? ring[rd_addr] : 64'd0;
    if (state == S_IDLE && req_take && req.cmd == CMD_STORE
        && req.idx < 32'(RING_SIZE)) begin
      ring[req.idx[AW-1:0]] <= req.sval;
    end else if (state == S_FILL_WR) begin
      ring[walk_nx] <= walk_v + gyro_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_ok <= '0;
      cnt_ok  <= '0;
    end else begin
      if (req_take && req.cmd == CMD_STORE && req.idx < 32'(RING_SIZE))
        ring_ok[req.idx[AW-1:0]] <= 1'b1;
      if (state == S_FILL_WR) ring_ok[walk_nx] <= 1'b1;
      if (state == S_CHECK && (cur.cmd == CMD_SPLIT || cur.cmd == CMD_READ)) begin
        if (ctr_v == 8'd0) cnt_ok[prv] <= 1'b0;
        if (cur.cmd == CMD_SPLIT && cur.cnt != 16'd0) cnt_ok[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CHECK && cur.cmd == CMD_SPLIT && cur.cnt != 16'd0)
      cnt_mem[idx] <= ctr_v + 8'd1;
  end

  assign trial = {rem, dvd[63]} - {49'd0, cur.cnt};

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (req_take) cur <= req;
      S_RD: begin
        ctr_v <= cnt_ok[idx] ? cnt_mem[idx] : 8'd0;
        walk  <= cur.fstart[AW-1:0];
      end
      S_RD_WAIT: cur_v <= rd_data;
      S_CHECK: begin
        prv_v <= rd_data;
        dvd   <= cur_v - rd_data;
        rem   <= '0;
        quo   <= '0;
        bitn  <= 7'd64;
      end
      S_DIV: begin
        if (bitn != 7'd0) begin
          if (!trial[64]) begin
            rem <= trial[63:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= {rem[62:0], dvd[63]};
            quo <= {quo[62:0], 1'b0};
          end
          dvd  <= {dvd[62:0], 1'b0};
          bitn <= bitn - 7'd1;
        end
      end
      S_MUL: prod <= quo * (64'(ctr_v) + 64'd1);
      S_ADD: cur_v <= prv_v + prod;
      S_FILL_WAIT: walk_v <= rd_data;
      S_FILL_WR: walk <= walk_nx;
      S_FINAL_WAIT: cur_v <= rd_data;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_OUT && cur.cmd != CMD_STORE) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      res.event_time <= cur.word;
      res.source     <= SRC_RAW;
      res.status     <= cur.status;
      res.clamped    <= 1'b0;
      if (cur.cmd == CMD_SPLIT) begin
        if (cur.cnt == 16'd0) begin
          res.status <= ST_ZERO_CNT;
        end else begin
          res.source <= SRC_SPLIT;
          if (cur_v > cur.now) begin
            res.event_time <= cur.now;
            res.clamped    <= 1'b1;
          end else begin
            res.event_time <= cur_v;
          end
        end
      end else if (cur.cmd == CMD_READ) begin
        res.source     <= SRC_RING;
        res.event_time <= cur_v;
      end
    end
  end

  `include "sensor_timestamp_reconstructor_core_macros.svh"
  `STR_ASSERT_IMPL(a_take_idle, clk, rst, req_take, state == S_IDLE, "take outside idle")
  `STR_ASSERT_NEXT(a_out_valid, clk, rst, state == S_OUT && cur.cmd != CMD_STORE, res_valid, "result lost")
  `STR_ASSERT_IMPL(a_no_overw, clk, rst, state == S_OUT, !res_valid, "result overwritten")
endmodule

// ===== rtl/sensor_timestamp_reconstructor_core.sv =====
// Top level of the sensor timestamp reconstructor
// Usage:
//  Input queue: drive the fields with push; a request is taken when push
//  is high and full is low. Stores write the frame ring and give no result.
//  Samples give one result each.
//  Result queue: while empty is low the result ports hold the oldest result;
//  pop takes it. A stalled receiver holds the result and fills a two-entry
//  request queue, after which full rises.
//  gyro_period is written with gyro_period_we; the user must write it only
//  at an idle moment, as the block itself does not enforce this. A split
//  sample runs 64 one-bit steps of the serial divider, and a ring read may
//  first forward-fill ring entries from fill_start up to the read index.
//  Throughput is set by the back end, which works on one request at a time.
//  Reset clears the queue, the ring and the counters at once (valid bits)
//  and loads gyro_period with 5000000.
`timescale 1ns / 1ps
module sensor_timestamp_reconstructor_core
  import str_pkg::*;
#(
  parameter int RING_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        gyro_period_we,
  input  logic [63:0] gyro_period_wdata,
  input  logic        push,
  output logic        full,
  input  logic        operation,
  input  logic        msg_kind,
  input  logic [63:0] frame_word,
  input  logic [63:0] now_time,
  input  logic [4:0]  fill_start,
  input  logic [4:0]  store_index,
  input  logic [63:0] store_value,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] event_time,
  output logic [1:0]  source,
  output logic [1:0]  status,
  output logic        clamped
);
  logic [63:0] gyro_period;
  req_t        f_req, q_req;
  logic        q_empty, q_take, res_valid;
  res_t        res;

  always_ff @(posedge clk) begin
    if (rst) gyro_period <= GYRO_RESET;
    else if (gyro_period_we) gyro_period <= gyro_period_wdata;
  end

  str_front #(.RING_SIZE(RING_SIZE)) u_front (
    .operation, .msg_kind, .frame_word, .now_time, .fill_start,
    .store_index, .store_value, .req(f_req)
  );

  str_fifo u_fifo (
    .clk, .rst, .wr(push), .wdata(f_req), .full,
    .rd(q_take), .rdata(q_req), .empty(q_empty)
  );

  str_back #(.RING_SIZE(RING_SIZE)) u_back (
    .clk, .rst, .gyro_period, .req_valid(!q_empty), .req(q_req),
    .req_take(q_take), .res_valid, .res, .res_take(pop)
  );

  assign empty      = !res_valid;
  assign event_time = res.event_time;
  assign source     = res.source;
  assign status     = res.status;
  assign clamped    = res.clamped;
endmodule
